>>> rtl/ris_pkg.sv
// ----------------------------------------------------------------------------
// Record insertion sorter package
// Record, request, response and control types, shared constants and the
// key compare used by every insertion cell.
// ----------------------------------------------------------------------------
package ris_pkg;

   localparam int MAX_RECORDS = 32;
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SORT_KEY   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DESCENDING = CSR_IDX_W'(1);

   localparam logic KEY_ID     = 1'b0;
   localparam logic KEY_SALARY = 1'b1;

   typedef struct packed {
      logic signed [31:0] id;
      logic [63:0]        tag;
      logic [31:0]        salary;
   } rec_type;

   typedef struct packed {
      logic signed [31:0] record_id;
      logic [63:0]        name_tag;
      logic [31:0]        salary;
      logic               last_record;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_id;
      logic [63:0]        out_name_tag;
      logic [31:0]        out_salary;
      logic               out_last;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic sort_key;
      logic descending;
   } cfg_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_INSERT = 2'b01,
      ST_DRAIN  = 2'b10
   } state_type;

   function automatic logic [31:0] key_of(input rec_type r, input logic sort_key);
      logic [31:0] k;
      if (sort_key == KEY_SALARY) begin
         k = r.salary;
      end else begin
         k = {~r.id[31], r.id[30:0]};
      end
      return k;
   endfunction

   // stored record moves past the incoming one
   function automatic logic must_shift(input rec_type stored, input rec_type incoming,
                                       input cfg_type cfg);
      logic [31:0] a;
      logic [31:0] b;
      a = key_of(stored, cfg.sort_key);
      b = key_of(incoming, cfg.sort_key);
      return cfg.descending ? (a < b) : (a > b);
   endfunction

endpackage

>>> rtl/ris_cell.sv
// ----------------------------------------------------------------------------
// Record insertion cell
// Holds one record of the sorted chain. On insert it keeps its record, takes
// the neighbor below or takes the new record; on drain it takes from above.
// ----------------------------------------------------------------------------
module ris_cell (
   input  logic                   clock,
   input  ris_pkg::cfg_type       cfg,
   input  ris_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  ris_pkg::rec_type       new_rec,
   input  ris_pkg::rec_type       below_rec,
   input  ris_pkg::rec_type       above_rec,
   input  logic                   run_above,
   input  logic                   run_below,
   output logic                   run,
   output ris_pkg::rec_type       rec
);
   import ris_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;

   assign run = (!occupied || must_shift(rec_ff, new_rec, cfg)) && run_above;
   assign rec = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.insert && run) begin
         rec_in = run_below ? below_rec : new_rec;
      end else if (ctrl.drain) begin
         rec_in = above_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

>>> rtl/record_insertion_sorter.sv
// ----------------------------------------------------------------------------
// Record insertion sorter
// Chain of insertion cells keeping a set of records in stable sorted order;
// the last record of a set releases the sorted set through an output register.
// ----------------------------------------------------------------------------
// Insert: one request per cycle while not stalled; each record is written into its sorted place.
// Release: a set of N records streams out at one response per cycle while rsp_stall
//   is low, the first once the state register has moved to drain; requests stay stalled
//   until the final response of the set is loaded into the output register.
// Reset: synchronous, clears count, drop flag, state, config and output valid only.
module record_insertion_sorter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ris_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ris_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ris_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ris_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ris_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                drop_ff, drop_in;
   cfg_type             cfg_ff, cfg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                full;
   logic                load;
   cell_ctrl_type       ctrl;
   rec_type             new_rec;
   rec_type             cell_rec [MAX_RECORDS];
   logic                cell_run [MAX_RECORDS];

   assign req_stall = (state_ff != ST_INSERT);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign accept = req_valid && !req_stall;
   assign full   = (count_ff == CNT_W'(MAX_RECORDS));
   assign load   = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);

   assign new_rec.id     = req_data.record_id;
   assign new_rec.tag    = req_data.name_tag;
   assign new_rec.salary = req_data.salary;

   assign ctrl.insert = accept && !full;
   assign ctrl.drain  = load;

   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      rec_type below_rec;
      rec_type above_rec;
      logic    run_above;
      logic    run_below;

      if (i == 0) begin : g_bottom
         assign below_rec = new_rec;
         assign run_below = 1'b0;
      end else begin : g_mid_low
         assign below_rec = cell_rec[i-1];
         assign run_below = cell_run[i-1];
      end

      if (i == MAX_RECORDS - 1) begin : g_top
         assign above_rec = cell_rec[i];
         assign run_above = 1'b1;
      end else begin : g_mid_high
         assign above_rec = cell_rec[i+1];
         assign run_above = cell_run[i+1];
      end

      ris_cell u_cell (
         .clock     (clock),
         .cfg       (cfg_ff),
         .ctrl      (ctrl),
         .occupied  (count_ff > CNT_W'(i)),
         .new_rec   (new_rec),
         .below_rec (below_rec),
         .above_rec (above_rec),
         .run_above (run_above),
         .run_below (run_below),
         .run       (cell_run[i]),
         .rec       (cell_rec[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      cfg_in       = cfg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SORT_KEY) begin
            cfg_in.sort_key = csr_data[0];
         end else if (csr_index == CSR_DESCENDING) begin
            cfg_in.descending = csr_data[0];
         end
      end

      unique case (state_ff)
         ST_INSERT: begin
            if (accept) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last_record) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (load) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_id        = cell_rec[0].id;
               rsp_data_in.out_name_tag  = cell_rec[0].tag;
               rsp_data_in.out_salary    = cell_rec[0].salary;
               rsp_data_in.out_last      = (count_ff == CNT_W'(1));
               rsp_data_in.overflow      = drop_ff;
               count_in                  = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  drop_in  = 1'b0;
                  state_in = ST_INSERT;
               end
            end
         end
         default: begin
            state_in = ST_INSERT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INSERT;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> rtl/ris_checker.sv
// ----------------------------------------------------------------------------
// Record insertion sorter checker
// Port-level properties of the sorter, bound to the top level.
// ----------------------------------------------------------------------------
module ris_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ris_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ris_pkg::rsp_type rsp_data
);
   import ris_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_record |=> req_stall)
      else $error("request taken right after last record");

   a_busy_mid_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_last |-> req_stall)
      else $error("request open while set still releasing");

endmodule

bind record_insertion_sorter ris_checker u_ris_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> sim/tb_record_insertion_sorter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Record insertion sorter testbench
// Streams sets of records through the sorter under every key and direction,
// predicts each released set with a behavioral stable insertion sort and
// checks every response field by field. Covers field extremes, equal keys,
// order changes inside a set, full-store drops and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_record_insertion_sorter;
   import ris_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int ITEM_TARGET = 500;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   rec_type held_rec [MAX_RECORDS];
   int      held_count    = 0;
   bit      held_dropped  = 1'b0;
   logic    ord_key       = KEY_ID;
   logic    ord_desc      = 1'b0;
   rsp_type expected_sorted [$];

   int  items_sent      = 0;
   int  results_checked = 0;
   int  sets_released   = 0;
   int  overflow_sets   = 0;
   int  fail_count      = 0;
   int  quiet_cycles    = 0;
   int  stall_left      = 0;
   bit  req_steady      = 1'b0;
   bit  rsp_steady      = 1'b0;
   rsp_type want;

   record_insertion_sorter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // stored record moves up past the arriving one
   function automatic bit moves_past(input rec_type held_r, input rec_type new_r);
      logic signed [32:0] a;
      logic signed [32:0] b;
      if (ord_key == KEY_SALARY) begin
         a = {1'b0, held_r.salary};
         b = {1'b0, new_r.salary};
      end else begin
         a = {held_r.id[31], held_r.id};
         b = {new_r.id[31], new_r.id};
      end
      return ord_desc ? (a < b) : (a > b);
   endfunction

   function automatic req_type mk_rec(input logic [31:0] id, input logic [63:0] tag,
                                      input logic [31:0] salary, input bit last);
      req_type r;
      r.record_id   = id;
      r.name_tag    = tag;
      r.salary      = salary;
      r.last_record = last;
      return r;
   endfunction

   function automatic req_type rand_rec(input bit last);
      logic [31:0] id;
      logic [31:0] sal;
      id  = ($urandom_range(0, 1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 6)) - 32'd3;
      sal = ($urandom_range(0, 1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 4));
      return mk_rec(id, {32'($urandom), 32'($urandom)}, sal, last);
   endfunction

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   task automatic sort_in(input req_type r);
      rec_type nr;
      rsp_type e;
      int pos;
      nr.id     = r.record_id;
      nr.tag    = r.name_tag;
      nr.salary = r.salary;
      if (held_count < MAX_RECORDS) begin
         pos = held_count;
         while (pos > 0 && moves_past(held_rec[pos-1], nr)) begin
            held_rec[pos] = held_rec[pos-1];
            pos--;
         end
         held_rec[pos] = nr;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (r.last_record) begin
         for (int k = 0; k < held_count; k++) begin
            e.out_id       = held_rec[k].id;
            e.out_name_tag = held_rec[k].tag;
            e.out_salary   = held_rec[k].salary;
            e.out_last     = (k == held_count - 1);
            e.overflow     = held_dropped;
            expected_sorted.push_back(e);
         end
         sets_released++;
         if (held_dropped) overflow_sets++;
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endtask

   task automatic send_request(input req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sort_in(r);
      items_sent++;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_set(input int n);
      for (int i = 0; i < n; i++) send_request(rand_rec(i == n - 1));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_SORT_KEY) ord_key = val[0];
      else if (idx == CSR_DESCENDING) ord_desc = val[0];
   endtask

   // drop the request, wait for the released set to leave, then program key and direction
   task automatic set_order(input logic key, input logic desc);
      req_valid <= 1'b0;
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(CSR_SORT_KEY, {7'($urandom), key});
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_IDX_W'($urandom_range(2, 2**CSR_IDX_W - 1)), 8'($urandom));
      write_reg(CSR_DESCENDING, {7'($urandom), desc});
      csr_valid <= 1'b0;
   endtask

   task automatic test_extremes();
      set_order(KEY_ID, 1'b0);
      send_request(mk_rec(32'h7FFF_FFFF, '1, 32'hFFFF_FFFF, 1'b0));
      send_request(mk_rec(32'h8000_0000, '0, 32'h0, 1'b0));
      send_request(mk_rec(32'h0, 64'hA5A5_5A5A_F00F_0FF0, 32'h8000_0000, 1'b0));
      send_request(mk_rec(32'hFFFF_FFFF, 64'h1, 32'h1, 1'b0));
      send_request(mk_rec(32'h1, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF, 1'b1));
      send_request(mk_rec(32'h1234_5678, 64'h5A5A_A5A5_0FF0_F00F, 32'hDEAD_BEEF, 1'b1));
   endtask

   task automatic test_orders();
      for (int k = 0; k < 2; k++) begin
         for (int d = 0; d < 2; d++) begin
            set_order(k[0], d[0]);
            send_request(mk_rec(32'd5, {k[7:0], d[7:0], 48'h1}, 32'd100, 1'b0));
            send_request(mk_rec(-32'sd2, {k[7:0], d[7:0], 48'h2}, 32'd100, 1'b0));
            send_request(mk_rec(32'd5, {k[7:0], d[7:0], 48'h3}, 32'd40, 1'b1));
         end
      end
   endtask

   task automatic test_mid_set_change();
      set_order(KEY_ID, 1'b0);
      send_request(mk_rec(32'd7, 64'h11, 32'd3, 1'b0));
      send_request(mk_rec(-32'sd7, 64'h12, 32'd9, 1'b0));
      set_order(KEY_SALARY, 1'b1);
      send_request(mk_rec(32'd0, 64'h13, 32'd5, 1'b0));
      send_request(mk_rec(32'd1, 64'h14, 32'd9, 1'b1));
   endtask

   task automatic test_store_full();
      set_order(KEY_SALARY, 1'b0);
      send_set(MAX_RECORDS);
      set_order(KEY_ID, 1'b1);
      send_set(MAX_RECORDS + 1);
      req_steady = 1'b1;
      send_set(MAX_RECORDS + 8);
      req_steady = 1'b0;
   endtask

   task automatic test_random();
      int pick;
      int n;
      int cut;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 2) == 0) set_order($urandom_range(0, 1), $urandom_range(0, 1));
         req_steady = ($urandom_range(0, 4) == 0);
         rsp_steady = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 70) n = $urandom_range(1, 8);
         else if (pick < 93) n = $urandom_range(9, MAX_RECORDS);
         else n = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 8);
         if (n > 2 && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, n - 1);
            for (int i = 0; i < cut; i++) send_request(rand_rec(1'b0));
            set_order($urandom_range(0, 1), $urandom_range(0, 1));
            for (int i = cut; i < n; i++) send_request(rand_rec(i == n - 1));
         end else begin
            send_set(n);
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_steady) begin
         rsp_stall <= 1'b0;
      end else begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_sorted.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: response with none pending: id=%0d tag=%h salary=%h",
                        $realtime, rsp_data.out_id, rsp_data.out_name_tag, rsp_data.out_salary);
         end else begin
            want = expected_sorted.pop_front();
            if (rsp_data.out_id !== want.out_id || rsp_data.out_name_tag !== want.out_name_tag ||
                rsp_data.out_salary !== want.out_salary || rsp_data.out_last !== want.out_last ||
                rsp_data.overflow !== want.overflow) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: mismatch expected id=%0d tag=%h salary=%h last=%b ovf=%b",
                           $realtime, want.out_id, want.out_name_tag, want.out_salary,
                           want.out_last, want.overflow);
                  $display("%0t:          actual   id=%0d tag=%h salary=%h last=%b ovf=%b",
                           $realtime, rsp_data.out_id, rsp_data.out_name_tag,
                           rsp_data.out_salary, rsp_data.out_last, rsp_data.overflow);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles without a handshake", QUIET_LIMIT);
      $display("FAIL record_insertion_sorter");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_orders();
      test_mid_set_change();
      test_store_full();
      test_random();
      req_valid <= 1'b0;
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("sent %0d records in %0d sets under all key and direction settings",
               items_sent, sets_released);
      $display("checked %0d sorted records, %0d sets with dropped records, %0d failures",
               results_checked, overflow_sets, fail_count);
      if (fail_count == 0) begin
         $display("PASS record_insertion_sorter");
      end else begin
         $display("FAIL record_insertion_sorter");
      end
      $finish;
   end

endmodule
